### hdl/card_deck_shuffler_top_macros.svh
// ----------------------------------------------------------------------------
// Card deck shuffler assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CARD_DECK_SHUFFLER_TOP_MACROS_SVH
`define CARD_DECK_SHUFFLER_TOP_MACROS_SVH

// same-cycle implication
`define CDS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// Card deck shuffler package
// Widths, deck constants, card encoding and controller state type.
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int CDS_DECKS          = 1;
   localparam int CDS_CARDS_PER_DECK = 52;
   localparam int CDS_RANKS          = 13;
   localparam int CDS_SUITS          = 4;

   localparam int CDS_RND_W     = 31;
   localparam int CDS_BIT_CNT_W = $clog2(CDS_RND_W);
   localparam int CDS_POS_W     = 9;
   localparam int CDS_SUIT_W    = 2;
   localparam int CDS_RANK_W    = 4;
   localparam int CDS_CARD_W    = CDS_SUIT_W + CDS_RANK_W;

   typedef logic [CDS_SUIT_W-1:0] suit_type;
   typedef logic [CDS_RANK_W-1:0] rank_type;
   typedef logic [CDS_CARD_W-1:0] card_type;

   typedef enum logic [2:0] {
      ST_INIT,    // store fill after reset
      ST_IDLE,
      ST_DIV,     // bit-serial remainder
      ST_RD_R,
      ST_WR_I,
      ST_WR_R
   } state_type;

   function automatic card_type make_card(suit_type suit, rank_type rank);
      return {suit, rank};
   endfunction

endpackage

### hdl/cds_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/card_deck_shuffler_top.sv
// Order: an accepted request beat runs the bit-serial remainder (one random bit
//   per cycle), then the store read-swap-write through the single read port of
//   the card RAM; its result beat is registered as the swap writes position i,
//   the swap waiting while the result register is full. Only idle takes requests.
// Reset: synchronous; after reset the store is refilled with the ordered deck,
//   one entry per cycle, with req_ready low until all 52*DECKS entries are written.
// ----------------------------------------------------------------------------
// Card deck shuffler top level
// Fisher-Yates shuffle over a RAM card store; one fixed card per random beat.
// ----------------------------------------------------------------------------
`include "card_deck_shuffler_top_macros.svh"

module card_deck_shuffler_top
   import cds_pkg::*;
#(
   parameter int DECKS = CDS_DECKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CDS_RND_W-1:0] req_random_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CDS_POS_W-1:0] rsp_position,
   output logic [CDS_SUIT_W-1:0] rsp_suit,
   output logic [CDS_RANK_W-1:0] rsp_rank,
   output logic                 rsp_pass_done
);

   // N cards in the store; positions need POS_W bits, spans up to N need SPAN_W
   localparam int N      = CDS_CARDS_PER_DECK * DECKS;
   localparam int POS_W  = $clog2(N);
   localparam int SPAN_W = $clog2(N + 1);

   localparam logic [POS_W-1:0]  LAST_POS = POS_W'(N - 1);
   localparam logic [SPAN_W-1:0] N_SPAN   = SPAN_W'(N);
   localparam logic [CDS_BIT_CNT_W-1:0] LAST_BIT = CDS_BIT_CNT_W'(CDS_RND_W - 1);
   localparam rank_type LAST_RANK = CDS_RANK_W'(CDS_RANKS - 1);
   localparam suit_type LAST_SUIT = CDS_SUIT_W'(CDS_SUITS - 1);

   state_type state_ff, state_in;

   // fill sweep
   logic [POS_W-1:0] init_idx_ff, init_idx_in;
   rank_type         init_rank_ff, init_rank_in;
   suit_type         init_suit_ff, init_suit_in;

   // shuffle datapath
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CDS_RND_W-1:0]     rnd_ff, rnd_in;
   logic [CDS_BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SPAN_W-1:0]        span_ff, span_in;
   logic [SPAN_W-1:0]        rem_ff, rem_in;
   logic [POS_W-1:0]         r_ff, r_in;
   card_type                 held_ff, held_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CDS_POS_W-1:0] rsp_position_ff, rsp_position_in;
   card_type             rsp_card_ff, rsp_card_in;
   logic                 rsp_pass_done_ff, rsp_pass_done_in;

   // RAM port
   logic             ram_we;
   logic [POS_W-1:0] ram_wr_addr;
   card_type         ram_wr_data;
   logic [POS_W-1:0] ram_rd_addr;
   card_type         ram_rd_data;

   // control
   logic req_ready_c;
   logic rsp_load;
   logic out_free;
   logic last_pos;

   // remainder step
   logic [SPAN_W:0]   shifted;
   logic [SPAN_W:0]   diff;
   logic [SPAN_W-1:0] rem_step;
   logic [SPAN_W:0]   r_sum;

   cds_ram #(
      .WIDTH (CDS_CARD_W),
      .DEPTH (N)
   ) u_store (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_pos = (pos_ff == LAST_POS);

   // restoring remainder, one random bit per cycle, MSB first
   assign shifted  = {rem_ff, rnd_ff[CDS_RND_W-1]};
   assign diff     = shifted - {1'b0, span_ff};
   assign rem_step = (shifted >= {1'b0, span_ff}) ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
   // rem_step < span = N - pos, so r stays below N
   assign r_sum    = (SPAN_W + 1)'(pos_ff) + (SPAN_W + 1)'(rem_step);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_idx_ff == LAST_POS) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (bit_cnt_ff == LAST_BIT) state_in = ST_RD_R;
         end
         ST_RD_R: state_in = ST_WR_I;
         ST_WR_I: begin
            if (out_free) state_in = ST_WR_R;
         end
         ST_WR_R: state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready_c = 1'b0;
      rsp_load    = 1'b0;
      ram_we      = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = held_ff;
      ram_rd_addr = pos_ff;
      unique case (state_ff)
         ST_INIT: begin
            ram_we      = 1'b1;
            ram_wr_addr = init_idx_ff;
            ram_wr_data = make_card(init_suit_ff, init_rank_ff);
         end
         ST_IDLE: req_ready_c = 1'b1;
         ST_DIV:  ram_rd_addr = pos_ff;   // card at i, read ahead
         ST_RD_R: ram_rd_addr = r_ff;
         ST_WR_I: begin
            // hold the r address so read data stays put while stalled
            ram_rd_addr = r_ff;
            if (out_free) begin
               ram_we      = 1'b1;
               ram_wr_addr = pos_ff;
               ram_wr_data = ram_rd_data;
               rsp_load    = 1'b1;
            end
         end
         ST_WR_R: begin
            ram_rd_addr = r_ff;
            ram_we      = 1'b1;
            ram_wr_addr = r_ff;
            ram_wr_data = held_ff;
         end
         default: req_ready_c = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      init_idx_in  = init_idx_ff;
      init_rank_in = init_rank_ff;
      init_suit_in = init_suit_ff;
      pos_in       = pos_ff;
      rnd_in       = rnd_ff;
      bit_cnt_in   = bit_cnt_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      r_in         = r_ff;
      held_in      = held_ff;

      if (state_ff == ST_INIT) begin
         init_idx_in = init_idx_ff + POS_W'(1);
         if (init_rank_ff == LAST_RANK) begin
            init_rank_in = '0;
            init_suit_in = (init_suit_ff == LAST_SUIT) ? '0 : init_suit_ff + CDS_SUIT_W'(1);
         end else begin
            init_rank_in = init_rank_ff + CDS_RANK_W'(1);
         end
      end

      if (req_valid && req_ready_c) begin
         rnd_in     = req_random_word;
         bit_cnt_in = '0;
         rem_in     = '0;
         span_in    = N_SPAN - SPAN_W'(pos_ff);
      end

      if (state_ff == ST_DIV) begin
         rnd_in     = {rnd_ff[CDS_RND_W-2:0], 1'b0};
         rem_in     = rem_step;
         bit_cnt_in = bit_cnt_ff + CDS_BIT_CNT_W'(1);
         r_in       = r_sum[POS_W-1:0];
      end

      // read data now holds the card at i
      if (state_ff == ST_RD_R) begin
         held_in = ram_rd_data;
      end

      if (state_ff == ST_WR_R) begin
         pos_in = last_pos ? '0 : pos_ff + POS_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_position_in  = rsp_position_ff;
      rsp_card_in      = rsp_card_ff;
      rsp_pass_done_in = rsp_pass_done_ff;
      if (rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_position_in  = CDS_POS_W'(pos_ff);
         rsp_card_in      = ram_rd_data;   // card moved into position i
         rsp_pass_done_in = last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_idx_ff  <= '0;
         init_rank_ff <= '0;
         init_suit_ff <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         init_rank_ff <= init_rank_in;
         init_suit_ff <= init_suit_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff           <= rnd_in;
      bit_cnt_ff       <= bit_cnt_in;
      span_ff          <= span_in;
      rem_ff           <= rem_in;
      r_ff             <= r_in;
      held_ff          <= held_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_card_ff      <= rsp_card_in;
      rsp_pass_done_ff <= rsp_pass_done_in;
   end

   assign req_ready     = req_ready_c;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_suit      = rsp_card_ff[CDS_CARD_W-1:CDS_RANK_W];
   assign rsp_rank      = rsp_card_ff[CDS_RANK_W-1:0];
   assign rsp_pass_done = rsp_pass_done_ff;

   `CDS_ASSERT_NXT(a_accept_starts_div, req_valid && req_ready, state_ff == ST_DIV,
      "accepted beat did not start the remainder")
   `CDS_ASSERT_IMP(a_rem_below_span, state_ff == ST_DIV,
      (span_ff != '0) && (rem_ff < span_ff), "remainder out of range")
   `CDS_ASSERT_IMP(a_swap_in_range, state_ff == ST_RD_R,
      (r_ff >= pos_ff) && (r_ff <= LAST_POS), "swap index out of range")
   `CDS_ASSERT_IMP(a_pos_in_range, state_ff != ST_INIT, pos_ff <= LAST_POS,
      "shuffle position out of range")
   `CDS_ASSERT_IMP(a_pass_done_last, rsp_valid && rsp_pass_done,
      rsp_position == CDS_POS_W'(N - 1), "pass end flagged off the last position")

endmodule

### verif/card_deck_shuffler_checker.sv
// ----------------------------------------------------------------------------
// Card deck shuffler checker
// Tracks the card store and shuffle position from accepted random words, and
// compares each result beat with the oldest predicted card.
// ----------------------------------------------------------------------------
module card_deck_shuffler_checker
   import cds_pkg::*;
#(
   parameter int DECKS = CDS_DECKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CDS_RND_W-1:0]  req_random_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CDS_POS_W-1:0]  rsp_position,
   input  logic [CDS_SUIT_W-1:0] rsp_suit,
   input  logic [CDS_RANK_W-1:0] rsp_rank,
   input  logic                  rsp_pass_done,
   output int                    error_count,
   output int                    cards_owed
);

   localparam int CARD_COUNT = CDS_CARDS_PER_DECK * DECKS;
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [CDS_POS_W-1:0] position;
      suit_type             suit;
      rank_type             rank;
      logic                 pass_done;
   } dealt_card_type;

   card_type       shadow_deck [CARD_COUNT];
   int             shadow_pos = 0;
   dealt_card_type dealt_q [$];
   int             errors = 0;

   // ordered deck: by deck, then suit, then rank
   function automatic void order_deck();
      int slot;
      for (int k = 0; k < CARD_COUNT; k++) begin
         slot = k % CDS_CARDS_PER_DECK;
         shadow_deck[k] = {suit_type'(slot / CDS_RANKS), rank_type'(slot % CDS_RANKS)};
      end
      shadow_pos = 0;
   endfunction

   // one Fisher-Yates step: swap position with a pick from the unfixed tail
   function automatic dealt_card_type deal_next_card(logic [CDS_RND_W-1:0] word);
      dealt_card_type card;
      longint         span;
      int             pick;
      card_type       held;
      span = CARD_COUNT - shadow_pos;
      pick = shadow_pos + int'(longint'(word) % span);
      held = shadow_deck[shadow_pos];
      shadow_deck[shadow_pos] = shadow_deck[pick];
      shadow_deck[pick] = held;
      card.position  = CDS_POS_W'(shadow_pos);
      card.suit      = shadow_deck[shadow_pos][CDS_CARD_W-1:CDS_RANK_W];
      card.rank      = shadow_deck[shadow_pos][CDS_RANK_W-1:0];
      card.pass_done = (shadow_pos == CARD_COUNT - 1);
      shadow_pos     = card.pass_done ? 0 : shadow_pos + 1;
      return card;
   endfunction

   always @(posedge clock) begin
      dealt_card_type want;
      if (reset) begin
         order_deck();
         dealt_q.delete();
      end else begin
         // results first, so a beat can never match a card predicted this edge
         if (rsp_valid && rsp_ready) begin
            if (dealt_q.size() == 0) begin
               errors++;
               if (errors <= SHOWN_ERRORS)
                  $display("ERROR: unexpected card pos=%0d suit=%0d rank=%0d last=%0b",
                           rsp_position, rsp_suit, rsp_rank, rsp_pass_done);
            end else begin
               want = dealt_q.pop_front();
               if (rsp_position !== want.position || rsp_suit !== want.suit ||
                   rsp_rank !== want.rank || rsp_pass_done !== want.pass_done) begin
                  errors++;
                  if (errors <= SHOWN_ERRORS)
                     $display("ERROR: card mismatch exp pos=%0d suit=%0d rank=%0d last=%0b",
                              want.position, want.suit, want.rank, want.pass_done,
                              " got pos=%0d suit=%0d rank=%0d last=%0b",
                              rsp_position, rsp_suit, rsp_rank, rsp_pass_done);
               end
            end
         end
         if (req_valid && req_ready)
            dealt_q.push_back(deal_next_card(req_random_word));
      end
      error_count <= errors;
      cards_owed  <= dealt_q.size();
   end

endmodule

### verif/tb_card_deck_shuffler_top.sv
// ----------------------------------------------------------------------------
// Card deck shuffler testbench
// Feeds random words to the shuffler with random gaps and result stalls; the
// checker beside the block predicts every dealt card and counts mismatches.
// ----------------------------------------------------------------------------
module tb_card_deck_shuffler_top;
   import cds_pkg::*;

   localparam int DECKS        = CDS_DECKS;
   localparam int CARD_COUNT   = CDS_CARDS_PER_DECK * DECKS;
   localparam int RANDOM_BEATS = 1700;
   // leave room for stray late beats
   localparam int DRAIN_CYCLES = 80;
   // worst beat: longest gap + busy step + longest stall, times ~1725 beats, plus fill
   localparam int CYCLE_LIMIT  = 1_500_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CDS_RND_W-1:0]  req_random_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CDS_POS_W-1:0]  rsp_position;
   logic [CDS_SUIT_W-1:0] rsp_suit;
   logic [CDS_RANK_W-1:0] rsp_rank;
   logic                  rsp_pass_done;

   int   fail_count;
   int   cards_owed;
   int   cycle_count = 0;
   int   stall_left  = 0;
   // when set, neither side starts a new idle
   logic calm        = 1'b0;

   card_deck_shuffler_top #(
      .DECKS(DECKS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_random_word(req_random_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_suit       (rsp_suit),
      .rsp_rank       (rsp_rank),
      .rsp_pass_done  (rsp_pass_done)
   );

   card_deck_shuffler_checker #(
      .DECKS(DECKS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_random_word(req_random_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_suit       (rsp_suit),
      .rsp_rank       (rsp_rank),
      .rsp_pass_done  (rsp_pass_done),
      .error_count    (fail_count),
      .cards_owed     (cards_owed)
   );

   always #4 clock = ~clock;

   // idle length: mostly none or short, now and then longer than a whole step
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 5);
      if (roll < 97) return $urandom_range(6, 40);
      return $urandom_range(41, 120);
   endfunction

   // present one random word after a gap and hold it until accepted;
   // valid stays up across back-to-back beats
   task automatic send_card_word(input logic [CDS_RND_W-1:0] word, input int gap);
      if (gap > 0) begin
         req_valid       <= 1'b0;
         req_random_word <= CDS_RND_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_random_word <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random stalls, none started while calm
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog; also catches predicted cards that never show up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [CDS_RND_W-1:0] word;
      int                   roll;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: position k equals beat k from reset
      for (int k = 0; k < 24; k++) begin
         case (k % 6)
            0: word = '0;
            1: word = '1;
            2: word = CDS_RND_W'(1) << k;
            3: word = ~(CDS_RND_W'(1) << k);
            // remainder lands on the last card of the store
            4: word = CDS_RND_W'(CARD_COUNT - 1 - k);
            default: word = k[0] ? 31'h2AAA_AAAA : 31'h5555_5555;
         endcase
         send_card_word(word, (k < 12) ? 0 : pick_gap());
      end

      // random: whole passes wrap many times; calm stretches every so often
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 150 == 0)
            calm <= ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 9);
         if (roll < 2)
            word = CDS_RND_W'($urandom_range(0, 2 * CARD_COUNT));
         else if (roll < 3)
            word = '1 - CDS_RND_W'($urandom_range(0, CARD_COUNT));
         else
            word = CDS_RND_W'($urandom);
         send_card_word(word, calm ? 0 : pick_gap());
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // owed count is a registered copy of the checker's queue size
      @(posedge clock);
      while (cards_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/cds_pkg.sv
hdl/cds_ram.sv
hdl/card_deck_shuffler_top.sv
verif/card_deck_shuffler_checker.sv
verif/tb_card_deck_shuffler_top.sv
